### hdl/crfr_pkg.sv
// Shared types and constants of the confirmed frame release ring.
// No dependencies; used by crfr_mod and confirmed_frame_release_ring.
`default_nettype none

package crfr_pkg;

  // Field widths
  localparam int unsigned FRAME_W   = 32;
  localparam int unsigned TAG_W     = 31;
  localparam int unsigned PAY_W     = 64;
  localparam int unsigned PB_W      = 4;

  // Release burst limit per request and its counter width
  localparam int unsigned MAX_BURST = 32;
  localparam int unsigned CNT_W     = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUBLISH_ENABLE = 2'd0,
    REG_PAYLOAD_BYTES  = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

### hdl/crfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/crfr_mod.sv
// Slot index unit: remainder of a frame number by the ring depth through a
// reciprocal multiply, a back-multiply and one correction step, each registered.
// Depends on crfr_pkg.
`default_nettype none

module crfr_mod #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [crfr_pkg::TAG_W-1:0]       dividend_i,
  output logic                                  done_o,
  output logic      [$clog2(DEPTH)-1:0]         rem_o
);

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned RW      = IDX_W + 1;
  localparam int unsigned RECIP_W = crfr_pkg::TAG_W + 1 - IDX_W;
  localparam int unsigned PROD_W  = crfr_pkg::TAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << crfr_pkg::TAG_W) / DEPTH);

  logic                               mul_vld_q;
  logic                               sub_vld_q;
  logic                               fix_vld_q;
  logic                               done_q;
  logic [crfr_pkg::TAG_W-1:0]         x_q;
  logic [RW-1:0]                      quo_q, quo_d;
  logic [RW-1:0]                      dif_q, dif_d;
  logic [RW-1:0]                      rem_q, rem_d;
  logic [PROD_W-1:0]                  prod;
  logic [2*RW-1:0]                    qd;

  // Estimate the quotient low bits; the estimate is the true quotient or one less
  assign prod  = {{RECIP_W{1'b0}}, x_q} * {{crfr_pkg::TAG_W{1'b0}}, RECIP};
  assign quo_d = prod[crfr_pkg::TAG_W +: RW];

  // Subtract the back-multiplied estimate; the difference lies below twice the depth
  assign qd    = {{RW{1'b0}}, quo_q} * (2*RW)'(DEPTH);
  assign dif_d = x_q[RW-1:0] - qd[RW-1:0];

  // Fold the difference once into range
  assign rem_d = (dif_q >= RW'(DEPTH)) ? dif_q - RW'(DEPTH) : dif_q;

  // Advance the stage valids, pulse done after the last stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sub_vld_q <= 1'b0;
      fix_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      sub_vld_q <= mul_vld_q;
      fix_vld_q <= sub_vld_q;
      done_q    <= fix_vld_q;
    end
  end

  // Datapath registers need no reset; the dividend holds until the next start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
    end
    quo_q <= quo_d;
    dif_q <= dif_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

  // Remainder stays below the depth once finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < RW'(DEPTH)))
    else $error("remainder out of range");

  // A start never arrives while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !(mul_vld_q || sub_vld_q || fix_vld_q || done_q))
    else $error("index unit restarted while busy");

  // At most one stage holds a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_vld_q, sub_vld_q, fix_vld_q, done_q}))
    else $error("index unit holds two runs");

endmodule

`default_nettype wire

### hdl/confirmed_frame_release_ring.sv
// Top level of the confirmed frame release ring: slot RAM, valid bits,
// release sequencer. Depends on crfr_pkg, crfr_ram and crfr_mod.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   cmd_i, frame_number_i, payload_i
//  out      source     out_valid_o / out_stall_i out_frame_o, out_payload_o, out_last_o
//  cfg      sink       cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A record with a non-negative frame is accepted, passes the slot index unit
// (reciprocal multiply, back-multiply, correction) and is written to the RAM.
// A live request then reads and tag-checks each released frame in turn and
// ends with a closing check, as the RAM has one read port. A negative frame
// is only accepted.
// Reset clears the slot valid bits at once; no clearing pass follows.
// A stalled output holds the sequencer in its check state; input is stalled
// until the request's last result sits in the output register.
`default_nettype none

module confirmed_frame_release_ring #(
  parameter int unsigned RING_DEPTH = 32,
  parameter int unsigned LAG        = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input requests
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cmd_i,
  input  wire logic signed [crfr_pkg::FRAME_W-1:0] frame_number_i,
  input  wire logic [crfr_pkg::PAY_W-1:0]        payload_i,
  // Released frames
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [crfr_pkg::TAG_W-1:0]             out_frame_o,
  output logic [crfr_pkg::PAY_W-1:0]             out_payload_o,
  output logic                                   out_last_o,
  // Configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [crfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [crfr_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned ENT_W = crfr_pkg::TAG_W + crfr_pkg::PAY_W;
  localparam int unsigned BND_W = crfr_pkg::FRAME_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_CHK
  } state_e;

  state_e                          state_q;
  logic                            publish_enable_q;
  logic [crfr_pkg::PB_W-1:0]       payload_bytes_q;
  logic                            rel_q;
  logic [crfr_pkg::TAG_W-1:0]      rec_frame_q;
  logic [crfr_pkg::PAY_W-1:0]      rec_payload_q;
  logic signed [BND_W-1:0]         up_to_q;
  logic [crfr_pkg::FRAME_W-1:0]    fn_q;
  logic [IDX_W-1:0]                rel_idx_q;
  logic [crfr_pkg::CNT_W-1:0]      cnt_q;
  logic [RING_DEPTH-1:0]           valid_q;
  logic                            pend_q;
  logic [crfr_pkg::TAG_W-1:0]      pend_frame_q;
  logic [crfr_pkg::PAY_W-1:0]      pend_payload_q;
  logic                            out_valid_q;
  logic                            out_last_q;
  logic [crfr_pkg::TAG_W-1:0]      out_frame_q;
  logic [crfr_pkg::PAY_W-1:0]      out_payload_q;

  logic                            in_acc;
  logic                            out_free;
  logic                            out_load;
  logic                            div_done;
  logic [IDX_W-1:0]                div_rem;
  logic                            ram_we;
  logic [ENT_W-1:0]                ram_wdata;
  logic                            ram_re;
  logic [ENT_W-1:0]                ram_rdata;
  logic [crfr_pkg::TAG_W-1:0]      rd_tag;
  logic [crfr_pkg::PAY_W-1:0]      rd_payload;
  logic                            in_bound;
  logic                            hit;
  logic [crfr_pkg::PAY_W-1:0]      pay_mask;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_CHK) && pend_q && out_free;

  // Compute the slot index of an accepted record
  crfr_mod #(
    .DEPTH (RING_DEPTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && !frame_number_i[crfr_pkg::FRAME_W-1]),
    .dividend_i (frame_number_i[crfr_pkg::TAG_W-1:0]),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Slot store: tag and payload per ring entry
  assign ram_we    = (state_q == ST_MOD) && div_done;
  assign ram_wdata = {rec_frame_q, rec_payload_q};
  assign ram_re    = (state_q == ST_RD);

  crfr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (div_rem),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rel_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_tag     = ram_rdata[ENT_W-1:crfr_pkg::PAY_W];
  assign rd_payload = ram_rdata[crfr_pkg::PAY_W-1:0];

  // Check the frame wanted against bound, burst limit, valid bit and slot tag
  assign in_bound = up_to_q >= $signed({1'b0, fn_q});
  assign hit = in_bound && (cnt_q < crfr_pkg::CNT_W'(crfr_pkg::MAX_BURST)) &&
               valid_q[rel_idx_q] && ({1'b0, rd_tag} == fn_q);

  // Zero bytes at or above payload_bytes
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pay_mask[b*8 +: 8] = (payload_bytes_q > crfr_pkg::PB_W'(b)) ? 8'hFF : 8'h00;
    end
  end

  // Sequencer, configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      publish_enable_q <= 1'b1;
      payload_bytes_q  <= crfr_pkg::PB_W'(8);
      rel_q            <= 1'b0;
      fn_q             <= '0;
      rel_idx_q        <= '0;
      cnt_q            <= '0;
      valid_q          <= '0;
      pend_q           <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          crfr_pkg::REG_PUBLISH_ENABLE: publish_enable_q <= cfg_wdata_i[0];
          crfr_pkg::REG_PAYLOAD_BYTES:  payload_bytes_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      // Raise the output on a load, drop it once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            rel_q <= cmd_i && publish_enable_q;
            cnt_q <= '0;
            state_q <= frame_number_i[crfr_pkg::FRAME_W-1] ? ST_IDLE : ST_MOD;
          end
        end
        ST_MOD: begin
          if (div_done) begin
            valid_q[div_rem] <= 1'b1;
            state_q <= rel_q ? ST_RD : ST_IDLE;
          end
        end
        ST_RD: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (hit) begin
            if (!pend_q || out_free) begin
              pend_q    <= 1'b1;
              fn_q      <= fn_q + 1'b1;
              rel_idx_q <= (rel_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : rel_idx_q + 1'b1;
              cnt_q     <= cnt_q + 1'b1;
              state_q   <= ST_RD;
            end
          end else if (!pend_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            pend_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: held request, pending entry, output
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rec_frame_q   <= frame_number_i[crfr_pkg::TAG_W-1:0];
      rec_payload_q <= payload_i;
      up_to_q       <= $signed({frame_number_i[crfr_pkg::FRAME_W-1], frame_number_i}) -
                       $signed(BND_W'(LAG));
    end
    if (out_load) begin
      out_frame_q   <= pend_frame_q;
      out_payload_q <= pend_payload_q & pay_mask;
      out_last_q    <= !hit;
    end
    if (state_q == ST_CHK && hit && (!pend_q || out_free)) begin
      pend_frame_q   <= rd_tag;
      pend_payload_q <= rd_payload;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_frame_o   = out_frame_q;
  assign out_payload_o = out_payload_q;
  assign out_last_o    = out_last_q;

  // A pending entry exists only inside a release walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_RD || state_q == ST_CHK))
    else $error("pending entry outside release walk");

  // A non-final result always has its successor pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> pend_q)
    else $error("non-final result without successor");

  // Burst never exceeds its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= crfr_pkg::CNT_W'(crfr_pkg::MAX_BURST))
    else $error("release burst over limit");

  // Each walk step advances the wanted frame by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && hit && (!pend_q || out_free)) |=> (fn_q == $past(fn_q) + 1'b1))
    else $error("release frame did not advance");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench of confirmed_frame_release_ring: queued requests go through a driver, and released
// frames are checked in order against a ring predictor kept in the bench.
// Depends on crfr_pkg and the confirmed_frame_release_ring RTL.
module tb;

  localparam int RING_DEPTH    = 32;
  localparam int LAG           = 10;
  localparam int RELEASE_LIMIT = 32;
  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 100;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_LIVE   = 1'b1;
  localparam logic [crfr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [crfr_pkg::PAY_W-1:0] EDGE_PAY [4] = '{
    64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
  };

  typedef struct {
    logic                                cmd;
    logic signed [crfr_pkg::FRAME_W-1:0] frame;
    logic [crfr_pkg::PAY_W-1:0]          payload;
  } frame_req_t;

  typedef struct {
    logic [crfr_pkg::TAG_W-1:0] frame;
    logic [crfr_pkg::PAY_W-1:0] payload;
    logic                       last;
  } confirmed_t;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic                                cmd_i          = 1'b0;
  logic signed [crfr_pkg::FRAME_W-1:0] frame_number_i = '0;
  logic [crfr_pkg::PAY_W-1:0]          payload_i      = '0;
  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic [crfr_pkg::TAG_W-1:0]          out_frame_o;
  logic [crfr_pkg::PAY_W-1:0]          out_payload_o;
  logic                                out_last_o;
  logic                                cfg_we_i       = 1'b0;
  logic [crfr_pkg::CFG_IDX_W-1:0]      cfg_index_i    = '0;
  logic [crfr_pkg::CFG_W-1:0]          cfg_wdata_i    = '0;

  // Predictor copy of the ring and its registers
  int                         ring_tag     [RING_DEPTH];
  logic [crfr_pkg::PAY_W-1:0] ring_payload [RING_DEPTH];
  int                         released_through;
  logic                       publish_on;
  logic [crfr_pkg::CFG_W-1:0] payload_bytes;

  frame_req_t pending_requests [$];
  confirmed_t confirmed_frames [$];
  frame_req_t drive_req;
  confirmed_t want;
  int         gap_frames [$];
  int         next_frame      = 0;
  int         requests_queued = 0;
  int         requests_taken  = 0;
  int         failures        = 0;
  int         send_idle_pct   = 0;
  int         recv_idle_pct   = 0;

  confirmed_frame_release_ring #(
    .RING_DEPTH(RING_DEPTH),
    .LAG       (LAG)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .frame_number_i(frame_number_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_frame_o   (out_frame_o),
    .out_payload_o (out_payload_o),
    .out_last_o    (out_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Record the frame, then release in order what the live frame confirms
  task automatic record_and_release(input logic cmd, input int frame,
                                    input logic [crfr_pkg::PAY_W-1:0] pay);
    longint                     up_to;
    longint                     f;
    int                         slot;
    int                         count;
    logic [crfr_pkg::PAY_W-1:0] mask;
    confirmed_t                 item;
    count = 0;
    if (frame >= 0) begin
      slot = frame % RING_DEPTH;
      ring_tag[slot] = frame;
      ring_payload[slot] = pay;
    end
    if (cmd == CMD_LIVE && publish_on) begin
      if (payload_bytes >= 8) begin
        mask = '1;
      end else begin
        mask = (64'd1 << (8 * payload_bytes)) - 64'd1;
      end
      up_to = longint'(frame) - LAG;
      f = longint'(released_through) + 1;
      // stop at the burst limit or at the first slot holding another frame
      while (f <= up_to && count < RELEASE_LIMIT &&
             longint'(ring_tag[int'(f % RING_DEPTH)]) == f) begin
        item.frame = f[crfr_pkg::TAG_W-1:0];
        item.payload = ring_payload[int'(f % RING_DEPTH)] & mask;
        item.last = 1'b0;
        confirmed_frames.push_back(item);
        released_through = int'(f);
        count++;
        f++;
      end
      if (count > 0) begin
        confirmed_frames[confirmed_frames.size() - 1].last = 1'b1;
      end
    end
  endtask

  function automatic logic [crfr_pkg::PAY_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_request(input logic cmd, input int frame,
                                       input logic [crfr_pkg::PAY_W-1:0] pay);
    frame_req_t req;
    req.cmd = cmd;
    req.frame = frame;
    req.payload = pay;
    pending_requests.push_back(req);
    requests_queued++;
  endfunction

  // Mostly a live path with skips, rollbacks and replays; some noise
  task automatic queue_frame_play(input int n);
    int counted;
    int pick;
    int k;
    int j;
    int slot;
    int big;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(99);
      if (gap_frames.size() != 0 && (next_frame - gap_frames[0] > 12 || pick < 10)) begin
        // fill the oldest skipped frame with a rollback record
        push_request(CMD_RECORD, gap_frames.pop_front(), rand_payload());
        counted++;
      end else if (pick < 58) begin
        push_request(CMD_LIVE, next_frame, rand_payload());
        next_frame++;
        counted++;
      end else if (pick < 70) begin
        // skip one frame on the live path
        gap_frames.push_back(next_frame);
        push_request(CMD_LIVE, next_frame + 1, rand_payload());
        next_frame += 2;
        counted++;
      end else if (pick < 84) begin
        // rewrite a recent frame
        k = next_frame - 1 - int'($urandom_range(12));
        if (k >= 0) begin
          push_request(CMD_RECORD, k, rand_payload());
          counted++;
        end
      end else if (pick < 92) begin
        // negative frame: ignored whatever the command
        push_request(1'($urandom_range(1)),
                     ($urandom_range(3) == 0) ? -1 : int'($urandom | 32'h8000_0000),
                     rand_payload());
      end else if (pick < 97) begin
        // stray far frame, then restore the slot it took
        big = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF
                                       : int'(($urandom & 32'h7FFF_FFFF) | 32'h4000_0000);
        push_request(1'($urandom_range(1)), big, rand_payload());
        counted++;
        slot = big % RING_DEPTH;
        if (next_frame - 1 >= slot) begin
          k = next_frame - 1 - ((next_frame - 1 - slot) % RING_DEPTH);
          push_request(CMD_RECORD, k, rand_payload());
          counted++;
        end
      end else begin
        // fill every gap, replay a run of frames, then a far live frame drains the backlog
        while (gap_frames.size() != 0) begin
          push_request(CMD_RECORD, gap_frames.pop_front(), rand_payload());
          counted++;
        end
        k = $urandom_range(20, 12);
        for (j = 0; j < k; j++) begin
          push_request(CMD_RECORD, next_frame + j, rand_payload());
        end
        counted += k;
        next_frame += k;
        big = int'(($urandom & 32'h3FFF_FFE0) | 32'h4000_0000) | (next_frame % RING_DEPTH);
        push_request(CMD_LIVE, big, rand_payload());
        counted++;
      end
    end
  endtask

  // Hold until every request is taken and every release seen, then let the block settle
  task automatic wait_drained();
    while (requests_taken != requests_queued || confirmed_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [crfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [crfr_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      crfr_pkg::REG_PUBLISH_ENABLE: publish_on = data[0];
      crfr_pkg::REG_PAYLOAD_BYTES:  payload_bytes = data;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic publish, input logic [crfr_pkg::CFG_W-1:0] nbytes,
                           input int n, input int s_pct, input int r_pct);
    wait_drained();
    write_reg(crfr_pkg::REG_PUBLISH_ENABLE, {3'b000, publish});
    write_reg(crfr_pkg::REG_PAYLOAD_BYTES, nbytes);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    // restart the live path just past the last released frame
    next_frame = released_through + 1;
    gap_frames.delete();
    queue_frame_play(n);
  endtask

  // Request driver: predict on acceptance, then present the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        record_and_release(cmd_i, frame_number_i, payload_i);
        requests_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= drive_req.cmd;
          frame_number_i <= drive_req.frame;
          payload_i <= drive_req.payload;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Release monitor: compare each accepted frame with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (confirmed_frames.size() == 0) begin
          $display("%0t: unexpected release, expected none, actual frame %0d", $time,
                   out_frame_o);
          failures++;
        end else begin
          want = confirmed_frames.pop_front();
          if (out_frame_o !== want.frame) begin
            $display("%0t: out_frame expected %0d actual %0d", $time, want.frame,
                     out_frame_o);
            failures++;
          end
          if (out_payload_o !== want.payload) begin
            $display("%0t: out_payload expected %h actual %h", $time, want.payload,
                     out_payload_o);
            failures++;
          end
          if (out_last_o !== want.last) begin
            $display("%0t: out_last expected %b actual %b", $time, want.last, out_last_o);
            failures++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_tag[i] = -1;
      ring_payload[i] = '0;
    end
    released_through = -1;
    publish_on = 1'b1;
    payload_bytes = 4'd8;
    send_idle_pct = 14;
    recv_idle_pct = 52;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored negative frames, in-order release, a gap filled late,
    // a rewrite before release, and a far live frame that drains the backlog
    push_request(CMD_LIVE, -1, EDGE_PAY[0]);
    push_request(CMD_RECORD, int'(32'h8000_0000), EDGE_PAY[0]);
    for (int f = 0; f < 12; f++) begin
      push_request(CMD_LIVE, f, EDGE_PAY[f % 4]);
    end
    push_request(CMD_LIVE, 13, EDGE_PAY[2]);
    push_request(CMD_RECORD, 12, EDGE_PAY[3]);
    push_request(CMD_RECORD, 5, 64'h0123_4567_89AB_CDEF);
    push_request(CMD_LIVE, 14, EDGE_PAY[0]);
    push_request(CMD_LIVE, 32'h7FFF_FFFF, EDGE_PAY[1]);
    push_request(CMD_RECORD, 32'h5555_5555, EDGE_PAY[0]);

    // Unknown register index must leave both registers alone
    wait_drained();
    write_reg(REG_UNUSED, '0);

    run_phase(1'b1, 4'd1, 20, 14, 52);
    run_phase(1'b0, 4'd8, 15, 14, 52);
    run_phase(1'b1, 4'd0, 20, 52, 14);
    run_phase(1'b1, 4'd15, 20, 52, 14);
    run_phase(1'b1, 4'd8, 20, 0, 0);
    run_phase(1'b1, 4'($urandom_range(7, 1)), 25, 0, 0);
    wait_drained();

    if (failures == 0) begin
      $display("PASS confirmed_frame_release_ring");
    end else begin
      $display("FAIL confirmed_frame_release_ring");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL confirmed_frame_release_ring");
    $finish;
  end

endmodule

### files.f
hdl/crfr_pkg.sv
hdl/crfr_ram.sv
hdl/crfr_mod.sv
hdl/confirmed_frame_release_ring.sv
dv/tb.sv
